[rtl/core/calcium_channel_gate_update_assert.svh]
// Assertion macros for the calcium channel gate update block.
// Included by the files that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef CALCIUM_CHANNEL_GATE_UPDATE_ASSERT_SVH
`define CALCIUM_CHANNEL_GATE_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CCG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CCG_ASSERT(lbl, prop, msg)
`define CCG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/core/ccg_pkg.sv]
// Shared types, constants and elaboration-time tables of the calcium channel gate update.
// Used by ccg_exp and calcium_channel_gate_update; depends on nothing else.
package ccg_pkg;

  localparam int unsigned TABLE_POINTS = 256;
  localparam int unsigned SEG_W        = $clog2(TABLE_POINTS);
  localparam int unsigned MINF_W       = 17;
  localparam int unsigned HINF_W       = 20;
  localparam int unsigned RATE_W       = 20;
  localparam int unsigned TAB_W        = 20;
  localparam int unsigned GATE_M_W     = 17;
  localparam int unsigned GATE_H_W     = 20;
  localparam int unsigned EXP_X_W      = 22;
  localparam int unsigned DECAY_W      = 31;
  localparam int unsigned GATE_DEPTH   = 1;
  localparam int unsigned GATE_AW      = 1;

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [63:0] TWO34     = 64'd1 << 34;
  localparam int unsigned EXP_TERMS = 12;

  // ceil(2^34 / k): floor(x / k) == (x * r) >> 34 for every x below 2^30.
  localparam logic [34:0] RECIP_Q34 [13] = '{
    35'd0, 35'd0,
    35'((TWO34 + 64'd1) / 64'd2),   35'((TWO34 + 64'd2) / 64'd3),
    35'((TWO34 + 64'd3) / 64'd4),   35'((TWO34 + 64'd4) / 64'd5),
    35'((TWO34 + 64'd5) / 64'd6),   35'((TWO34 + 64'd6) / 64'd7),
    35'((TWO34 + 64'd7) / 64'd8),   35'((TWO34 + 64'd8) / 64'd9),
    35'((TWO34 + 64'd9) / 64'd10),  35'((TWO34 + 64'd10) / 64'd11),
    35'((TWO34 + 64'd11) / 64'd12)
  };

  localparam logic [15:0]        COND_RST = 16'd256;
  localparam logic signed [15:0] REV_RST  = 16'sd15360;
  localparam logic [15:0]        DT_RST   = 16'd1024;

  typedef enum logic [1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_CONDUCTANCE = 2'd0,
    CFG_REVERSAL    = 2'd1,
    CFG_TIME_STEP   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [15:0] voltage;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  current;
    logic [GATE_M_W-1:0] activation;
    logic [GATE_H_W-1:0] inactivation;
  } out_item_t;

  typedef logic [TABLE_POINTS-1:0][MINF_W-1:0] minf_tab_t;
  typedef logic [TABLE_POINTS-1:0][HINF_W-1:0] hinf_tab_t;
  typedef logic [TABLE_POINTS-1:0][RATE_W-1:0] rate_tab_t;

  // The functions below only run at elaboration to fill the constant tables.
  function automatic logic [63:0] udiv_f(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_neg_f(input logic [63:0] x);
    logic [63:0]  y;
    logic [63:0]  n;
    logic [63:0]  u;
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [63:0]  tmp;
    logic [127:0] wide;
    if (x >= (64'd32 << 16)) begin
      return 64'd0;
    end
    y    = (x * 64'(LOG2E_Q30)) >> 30;
    n    = y >> 16;
    u    = ((y & 64'hFFFF) * 64'(LN2_Q30)) >> 16;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      tmp = (term * u) >> 30;
      if (k == 1) begin
        term = tmp;
      end else begin
        wide = 128'(tmp) * 128'(RECIP_Q34[k]);
        term = 64'(wide >> 34);
      end
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum >> n;
  endfunction

  function automatic logic [63:0] logistic_f(input logic signed [63:0] a);
    logic [63:0] mag;
    logic [63:0] e;
    mag = (a < 64'sd0) ? 64'(-a) : 64'(a);
    e   = exp_neg_f(mag);
    if (a >= 64'sd0) begin
      return udiv_f(Q30_ONE << 30, Q30_ONE + e);
    end
    return udiv_f(e << 30, Q30_ONE + e);
  endfunction

  function automatic logic signed [63:0] snum_f(input logic signed [63:0] v,
                                                input logic signed [63:0] c10);
    return v * 64'sd2560 - c10 * 64'sd65536;
  endfunction

  function automatic logic [63:0] gauss_f(input logic signed [63:0] q);
    logic [63:0] aq;
    aq = (q < 64'sd0) ? 64'(-q) : 64'(q);
    return exp_neg_f((aq * aq) >> 16);
  endfunction

  function automatic logic signed [63:0] point_v_f(input int i);
    return $signed((64'(i) * 64'd65536) / 64'(TABLE_POINTS - 1)) - 64'sd32768;
  endfunction

  function automatic minf_tab_t build_minf_f();
    minf_tab_t          t;
    logic signed [63:0] v;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      v    = point_v_f(i);
      t[i] = MINF_W'((logistic_f(snum_f(v, 64'sd56) / 64'sd75) + 64'd8192) >> 14);
    end
    return t;
  endfunction

  function automatic hinf_tab_t build_hinf_f();
    hinf_tab_t          t;
    logic signed [63:0] v;
    logic [63:0]        l1;
    logic [63:0]        l2;
    logic [63:0]        first;
    logic [63:0]        second;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      v      = point_v_f(i);
      l1     = logistic_f(snum_f(v, 64'sd249) / 64'sd120);
      l2     = logistic_f(-(snum_f(v, -64'sd205) / 64'sd81));
      first  = (64'd143 * l1) / 64'd100 + (64'd14 * Q30_ONE) / 64'd100;
      second = (64'd596 * l2) / 64'd100 + (64'd60 * Q30_ONE) / 64'd100;
      t[i]   = HINF_W'((first * second + (64'd1 << 43)) >> 44);
    end
    return t;
  endfunction

  function automatic rate_tab_t build_rate_m_f();
    rate_tab_t          t;
    logic signed [63:0] v;
    logic [63:0]        g1;
    logic [63:0]        g2;
    logic [63:0]        tau;
    logic [63:0]        tq;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      v    = point_v_f(i);
      g1   = gauss_f(snum_f(v, 64'sd52) / 64'sd60);
      g2   = gauss_f(snum_f(v, 64'sd14) / 64'sd300);
      tau  = (64'd29 * g1) / 64'd10 + (64'd19 * g2) / 64'd10 + (64'd23 * Q30_ONE) / 64'd10;
      tq   = tau >> 14;
      t[i] = (tq != 64'd0) ? RATE_W'(udiv_f(64'd1 << 36, tq)) : '0;
    end
    return t;
  endfunction

  function automatic rate_tab_t build_rate_h_f();
    rate_tab_t          t;
    logic signed [63:0] v;
    logic [63:0]        l1;
    logic [63:0]        l2;
    logic [63:0]        tau;
    logic [63:0]        tq;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      v    = point_v_f(i);
      l1   = logistic_f(-(snum_f(v, -64'sd230) / 64'sd50));
      l2   = logistic_f(-(snum_f(v, 64'sd287) / 64'sd37));
      tau  = (64'd4 * ((64'd446 * l1) / 64'd10 + (64'd364 * l2) / 64'd10
             + (64'd431 * Q30_ONE) / 64'd10)) / 64'd10;
      tq   = tau >> 14;
      t[i] = (tq != 64'd0) ? RATE_W'(udiv_f(64'd1 << 36, tq)) : '0;
    end
    return t;
  endfunction

  localparam minf_tab_t MINF_TAB   = build_minf_f();
  localparam hinf_tab_t HINF_TAB   = build_hinf_f();
  localparam rate_tab_t RATE_M_TAB = build_rate_m_f();
  localparam rate_tab_t RATE_H_TAB = build_rate_h_f();

endpackage

[rtl/core/ccg_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module ccg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/ccg_exp.sv]
// Iterative exp(-x) unit: Q16 argument, Q30 result, each term by multiply then divide.
// Depends on ccg_pkg for widths, constants and the reciprocal table.
module ccg_exp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ccg_pkg::EXP_X_W-1:0]     x_i,
  output logic                            done_o,
  output logic [ccg_pkg::DECAY_W-1:0]     value_o
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_UNIT,
    E_MUL,
    E_DIV,
    E_FIN
  } state_e;

  state_e      state_q;
  logic [3:0]  k_q;
  logic        done_q;
  logic [21:0] y_q;
  logic [5:0]  n_q;
  logic [29:0] u_q;
  logic [30:0] term_q;
  logic [30:0] sum_q;
  logic [30:0] tmp_q;
  logic [30:0] val_q;

  logic [51:0] y_prod;
  logic [45:0] u_prod;
  logic [60:0] tu_prod;
  logic [65:0] div_prod;
  logic [30:0] quot;

  assign y_prod   = 52'(x_i[20:0]) * 52'(ccg_pkg::LOG2E_Q30);
  assign u_prod   = 46'(y_q[15:0]) * 46'(ccg_pkg::LN2_Q30);
  assign tu_prod  = 61'(term_q) * 61'(u_q);
  assign div_prod = 66'(tmp_q) * 66'(ccg_pkg::RECIP_Q34[k_q]);
  assign quot     = (k_q == 4'd1) ? tmp_q : 31'(div_prod >> 34);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            // Arguments of 32 and above give exactly zero.
            if (x_i[21]) begin
              done_q <= 1'b1;
            end else begin
              state_q <= E_UNIT;
            end
          end
        end
        E_UNIT: begin
          k_q     <= 4'd1;
          state_q <= E_MUL;
        end
        E_MUL: begin
          state_q <= E_DIV;
        end
        E_DIV: begin
          if (k_q == 4'(ccg_pkg::EXP_TERMS)) begin
            state_q <= E_FIN;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= E_MUL;
          end
        end
        E_FIN: begin
          done_q  <= 1'b1;
          state_q <= E_IDLE;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      E_IDLE: begin
        if (start_i) begin
          y_q <= 22'(y_prod >> 30);
          if (x_i[21]) begin
            val_q <= '0;
          end
        end
      end
      E_UNIT: begin
        n_q    <= y_q[21:16];
        u_q    <= 30'(u_prod >> 16);
        term_q <= 31'(ccg_pkg::Q30_ONE);
        sum_q  <= 31'(ccg_pkg::Q30_ONE);
      end
      E_MUL: begin
        tmp_q <= 31'(tu_prod >> 30);
      end
      E_DIV: begin
        term_q <= quot;
        sum_q  <= k_q[0] ? (sum_q - quot) : (sum_q + quot);
      end
      E_FIN: begin
        val_q <= sum_q >> n_q;
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign value_o = val_q;

endmodule

[rtl/core/calcium_channel_gate_update.sv]
// Calcium channel gate update: table lookup, exponential-Euler gate relaxation and current.
// Depends on ccg_pkg, ccg_ram, ccg_exp and calcium_channel_gate_update_assert.svh.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   in       | in_valid_i / in_ready_o | in_data_i   (func, voltage)
//   out      | out_valid_o/out_ready_i | out_data_o  (current, activation, inactivation)
//   config   | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One item at a time. A set or query item passes through the interpolation, gate and
// current states to its result; an integrate step also waits for the two exp(-dt/tau)
// units, each computing twelve series terms, before it updates the gates.
// Reset clears the configuration to its defaults and the primed flag; until the first
// priming the gates read zero. A stalled output holds the next item at its last stage.
`include "calcium_channel_gate_update_assert.svh"

module calcium_channel_gate_update (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ccg_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ccg_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  localparam int unsigned SW  = ccg_pkg::SEG_W;
  localparam int unsigned MW  = ccg_pkg::GATE_M_W;
  localparam int unsigned HW  = ccg_pkg::GATE_H_W;
  localparam int unsigned TW  = ccg_pkg::TAB_W;
  localparam int unsigned DW  = ccg_pkg::DECAY_W;
  localparam int unsigned XW  = ccg_pkg::EXP_X_W;
  localparam int unsigned PW  = 16 + SW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INTERP,
    S_GATE,
    S_EXP,
    S_REL,
    S_UPD,
    S_CUR0,
    S_CUR1,
    S_CUR2,
    S_OUT
  } state_e;

  // Control state.
  state_e      state_q;
  logic [1:0]  icnt_q;
  logic        primed_q;
  logic        exp_start_q;
  logic        out_valid_q;
  logic        out_load;
  logic [15:0]        cond_q;
  logic signed [15:0] rev_q;
  logic [15:0]        dt_q;

  // Datapath registers.
  logic [1:0]         func_q;
  logic signed [15:0] volt_q;
  logic [SW-1:0]      seg_q;
  logic [15:0]        wgt_q;
  logic [MW-1:0]      mt_q;
  logic [HW-1:0]      ht_q;
  logic [TW-1:0]      rm_q;
  logic [TW-1:0]      rh_q;
  logic [MW-1:0]      m_q;
  logic [HW-1:0]      h_q;
  logic [XW-1:0]      xm_q;
  logic [XW-1:0]      xh_q;
  logic               mge_q;
  logic               hge_q;
  logic [MW-1:0]      pm_q;
  logic [HW-1:0]      ph_q;
  logic [32:0]        gm_q;
  logic [28:0]        gmh_q;
  logic [29:0]        mag_q;
  logic               neg_q;
  ccg_pkg::out_item_t out_q;

  // Lookup position of the incoming voltage.
  logic [15:0]   voff;
  logic [PW-1:0] pos;
  assign voff = {~in_data_i.voltage[15], in_data_i.voltage[14:0]};
  assign pos  = PW'(voff) * PW'(ccg_pkg::TABLE_POINTS - 1);

  // Shared interpolation: a + floor((b - a) * w / 65536).
  logic [SW-1:0]      seg_p1;
  logic [TW-1:0]      tab_a;
  logic [TW-1:0]      tab_b;
  logic signed [20:0] tab_d;
  logic signed [37:0] tab_dw;
  logic signed [21:0] tab_sum;
  logic [TW-1:0]      ival;

  assign seg_p1 = seg_q + 1'b1;

  always_comb begin
    case (icnt_q)
      2'd0: begin
        tab_a = TW'(ccg_pkg::MINF_TAB[seg_q]);
        tab_b = TW'(ccg_pkg::MINF_TAB[seg_p1]);
      end
      2'd1: begin
        tab_a = TW'(ccg_pkg::HINF_TAB[seg_q]);
        tab_b = TW'(ccg_pkg::HINF_TAB[seg_p1]);
      end
      2'd2: begin
        tab_a = TW'(ccg_pkg::RATE_M_TAB[seg_q]);
        tab_b = TW'(ccg_pkg::RATE_M_TAB[seg_p1]);
      end
      default: begin
        tab_a = TW'(ccg_pkg::RATE_H_TAB[seg_q]);
        tab_b = TW'(ccg_pkg::RATE_H_TAB[seg_p1]);
      end
    endcase
  end

  assign tab_d   = $signed({1'b0, tab_b}) - $signed({1'b0, tab_a});
  assign tab_dw  = 38'(tab_d) * 38'($signed({1'b0, wgt_q}));
  assign tab_sum = $signed({2'b00, tab_a}) + 22'(tab_dw >>> 16);
  assign ival    = tab_sum[TW-1:0];

  // Gate state memory; entry contents count only once primed.
  logic               ram_we;
  logic [MW+HW-1:0]   ram_wdata;
  logic [MW+HW-1:0]   ram_rdata;
  logic               ram_re;
  logic [MW-1:0]      m_new;
  logic [HW-1:0]      h_new;
  logic               do_snap;
  logic               do_integ;

  assign do_snap  = (func_q == ccg_pkg::FUNC_SET)
                    || ((func_q == ccg_pkg::FUNC_STEP) && !primed_q);
  assign do_integ = (func_q == ccg_pkg::FUNC_STEP) && primed_q;

  always_comb begin
    if (state_q == S_UPD) begin
      m_new = mge_q ? (mt_q + pm_q) : (mt_q - pm_q);
      h_new = hge_q ? (ht_q + ph_q) : (ht_q - ph_q);
    end else begin
      m_new = mt_q;
      h_new = ht_q;
    end
  end

  assign ram_re    = in_valid_i && in_ready_o;
  assign ram_we    = ((state_q == S_GATE) && do_snap) || (state_q == S_UPD);
  assign ram_wdata = {m_new, h_new};

  ccg_ram #(
    .WIDTH(MW + HW),
    .DEPTH(ccg_pkg::GATE_DEPTH)
  ) u_gate_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ccg_pkg::GATE_AW'(0)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ccg_pkg::GATE_AW'(0)),
    .rdata_o (ram_rdata)
  );

  // Decay factors.
  logic          exp_done_m;
  logic          exp_done_h;
  logic [DW-1:0] dec_m;
  logic [DW-1:0] dec_h;

  ccg_exp u_exp_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start_q),
    .x_i     (xm_q),
    .done_o  (exp_done_m),
    .value_o (dec_m)
  );

  ccg_exp u_exp_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start_q),
    .x_i     (xh_q),
    .done_o  (exp_done_h),
    .value_o (dec_h)
  );

  // Arithmetic between registers.
  logic [35:0]        xm_prod;
  logic [35:0]        xh_prod;
  logic [MW-1:0]      m_dlt;
  logic [HW-1:0]      h_dlt;
  logic [47:0]        rm_prod;
  logic [50:0]        rh_prod;
  logic [52:0]        gmh_prod;
  logic signed [16:0] vdiff;
  logic [16:0]        vabs;
  logic [45:0]        mag_prod;
  logic signed [31:0] cur;

  assign xm_prod  = 36'(dt_q) * 36'(rm_q);
  assign xh_prod  = 36'(dt_q) * 36'(rh_q);
  assign m_dlt    = (m_q >= mt_q) ? (m_q - mt_q) : (mt_q - m_q);
  assign h_dlt    = (h_q >= ht_q) ? (h_q - ht_q) : (ht_q - h_q);
  assign rm_prod  = 48'(m_dlt) * 48'(dec_m);
  assign rh_prod  = 51'(h_dlt) * 51'(dec_h);
  assign gmh_prod = 53'(gm_q) * 53'(h_q);
  assign vdiff    = 17'(volt_q) - 17'(rev_q);
  assign vabs     = vdiff[16] ? 17'(-vdiff) : 17'(vdiff);
  assign mag_prod = 46'(gmh_q) * 46'(vabs);
  // The magnitude stays below 2^30, so the signed result never needs clamping.
  assign cur      = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});

  // The result register takes a new transaction once the previous one is gone.
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer, configuration and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      icnt_q      <= '0;
      primed_q    <= 1'b0;
      exp_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      cond_q      <= ccg_pkg::COND_RST;
      rev_q       <= ccg_pkg::REV_RST;
      dt_q        <= ccg_pkg::DT_RST;
    end else begin
      exp_start_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ccg_pkg::CFG_CONDUCTANCE: cond_q <= cfg_wdata_i;
          ccg_pkg::CFG_REVERSAL:    rev_q  <= $signed(cfg_wdata_i);
          ccg_pkg::CFG_TIME_STEP:   dt_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            icnt_q  <= '0;
            state_q <= S_INTERP;
          end
        end
        S_INTERP: begin
          icnt_q <= icnt_q + 2'd1;
          if (icnt_q == 2'd3) begin
            state_q <= S_GATE;
          end
        end
        S_GATE: begin
          if (do_snap) begin
            primed_q <= 1'b1;
            state_q  <= S_CUR0;
          end else if (do_integ) begin
            exp_start_q <= 1'b1;
            state_q     <= S_EXP;
          end else begin
            state_q <= S_CUR0;
          end
        end
        S_EXP: begin
          if (exp_done_m) begin
            state_q <= S_REL;
          end
        end
        S_REL:  state_q <= S_UPD;
        S_UPD:  state_q <= S_CUR0;
        S_CUR0: state_q <= S_CUR1;
        S_CUR1: state_q <= S_CUR2;
        S_CUR2: state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_q <= in_data_i.func;
          volt_q <= in_data_i.voltage;
          seg_q  <= pos[PW-1:16];
          wgt_q  <= pos[15:0];
        end
      end
      S_INTERP: begin
        case (icnt_q)
          2'd0: begin
            mt_q <= MW'(ival);
            // Before priming the stored gates are meaningless and read as zero.
            m_q  <= primed_q ? ram_rdata[MW+HW-1:HW] : '0;
            h_q  <= primed_q ? ram_rdata[HW-1:0] : '0;
          end
          2'd1:    ht_q <= HW'(ival);
          2'd2:    rm_q <= ival;
          default: rh_q <= ival;
        endcase
      end
      S_GATE: begin
        if (do_snap) begin
          m_q <= m_new;
          h_q <= h_new;
        end
        xm_q <= xm_prod[35:14];
        xh_q <= xh_prod[35:14];
      end
      S_REL: begin
        mge_q <= m_q >= mt_q;
        hge_q <= h_q >= ht_q;
        pm_q  <= MW'(rm_prod >> 30);
        ph_q  <= HW'(rh_prod >> 30);
      end
      S_UPD: begin
        m_q <= m_new;
        h_q <= h_new;
      end
      S_CUR0: gm_q  <= 33'(cond_q) * 33'(m_q);
      S_CUR1: gmh_q <= 29'(gmh_prod >> 24);
      S_CUR2: begin
        mag_q <= 30'(mag_prod >> 16);
        neg_q <= vdiff[16];
      end
      S_OUT: begin
        if (out_load) begin
          out_q.current      <= cur;
          out_q.activation   <= m_q;
          out_q.inactivation <= h_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CCG_ASSERT(a_exp_lockstep, exp_done_m == exp_done_h, "decay units lost lockstep")
  `CCG_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second item taken")
  `CCG_ASSERT_NEXT(a_primed_sticky, primed_q, primed_q, "primed flag dropped")
  `CCG_ASSERT_NEXT(a_write_primes, ram_we, primed_q, "gate write left block unprimed")

endmodule

[verif/tb.sv]
// Self-checking testbench for calcium_channel_gate_update: directed items, then random traffic.
// Depends on ccg_pkg for the port types, function codes and register indexes.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int NPTS = ccg_pkg::TABLE_POINTS;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ccg_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ccg_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  calcium_channel_gate_update DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // Channel model state and its voltage tables.
  longint unsigned minf_lut[NPTS], hinf_lut[NPTS], rate_m_lut[NPTS], rate_h_lut[NPTS];
  longint unsigned g_nS, dt_step, act_m, inact_h;
  longint e_rev;
  bit gates_primed;

  ccg_pkg::out_item_t pending_results[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_off = 0;

  function automatic longint unsigned decay_q30(longint unsigned x);
    longint unsigned y, n, u, sum, term;
    if (x >= (64'd32 << 16)) return 0;
    y = (x * 64'd1549082005) >> 30;
    n = y >> 16;
    u = ((y & 64'hFFFF) * 64'd744261118) >> 16;
    sum = ONE_Q30;
    term = ONE_Q30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * u) >> 30) / k;
      if (k % 2) sum = sum - term;
      else sum = sum + term;
    end
    return sum >> n;
  endfunction

  function automatic longint unsigned sigmoid_q30(longint a);
    longint unsigned mag, e;
    mag = (a < 0) ? -a : a;
    e = decay_q30(mag);
    if (a >= 0) return (ONE_Q30 << 30) / (ONE_Q30 + e);
    return (e << 30) / (ONE_Q30 + e);
  endfunction

  function automatic longint norm_v(longint v, longint c10, longint s10);
    return (v * 2560 - c10 * 65536) / s10;
  endfunction

  function automatic longint unsigned bell_q30(longint q);
    longint unsigned aq;
    aq = (q < 0) ? -q : q;
    return decay_q30((aq * aq) >> 16);
  endfunction

  function automatic void build_luts();
    longint v;
    longint unsigned l1, l2, p1, p2, tau, tq;
    for (int i = 0; i < NPTS; i++) begin
      v = longint'((64'(i) * 64'd65536) / (NPTS - 1)) - 32768;
      minf_lut[i] = (sigmoid_q30(norm_v(v, 56, 75)) + 8192) >> 14;
      l1 = sigmoid_q30(norm_v(v, 249, 120));
      l2 = sigmoid_q30(-norm_v(v, -205, 81));
      p1 = 143 * l1 / 100 + 14 * ONE_Q30 / 100;
      p2 = 596 * l2 / 100 + 60 * ONE_Q30 / 100;
      hinf_lut[i] = (p1 * p2 + (64'd1 << 43)) >> 44;
      l1 = bell_q30(norm_v(v, 52, 60));
      l2 = bell_q30(norm_v(v, 14, 300));
      tau = 29 * l1 / 10 + 19 * l2 / 10 + 23 * ONE_Q30 / 10;
      tq = tau >> 14;
      rate_m_lut[i] = tq ? (64'd1 << 36) / tq : 0;
      l1 = sigmoid_q30(-norm_v(v, -230, 50));
      l2 = sigmoid_q30(-norm_v(v, 287, 37));
      tau = 4 * (446 * l1 / 10 + 364 * l2 / 10 + 431 * ONE_Q30 / 10) / 10;
      tq = tau >> 14;
      rate_h_lut[i] = tq ? (64'd1 << 36) / tq : 0;
    end
  endfunction

  function automatic longint unsigned lerp(ref longint unsigned t[NPTS],
                                           input longint unsigned s, input longint unsigned w);
    return (t[s] * (65536 - w) + t[s + 1] * w) >> 16;
  endfunction

  function automatic longint unsigned approach(longint unsigned old, longint unsigned tgt,
                                               longint unsigned d);
    if (old >= tgt) return tgt + (((old - tgt) * d) >> 30);
    return tgt - (((tgt - old) * d) >> 30);
  endfunction

  // Advances the gates for one transaction and returns the channel response.
  function automatic ccg_pkg::out_item_t gate_response(logic [1:0] fn, logic signed [15:0] volt);
    longint v, diff;
    longint unsigned pos, s, w, mt, ht, dm, dh, gmh, mag;
    ccg_pkg::out_item_t r;
    v = volt;
    pos = longint'(v + 32768) * (NPTS - 1);
    s = pos >> 16;
    w = pos & 64'hFFFF;
    mt = lerp(minf_lut, s, w);
    ht = lerp(hinf_lut, s, w);
    if (fn == ccg_pkg::FUNC_SET || (fn == ccg_pkg::FUNC_STEP && !gates_primed)) begin
      act_m = mt;
      inact_h = ht;
      gates_primed = 1;
    end else if (fn == ccg_pkg::FUNC_STEP) begin
      dm = decay_q30((dt_step * lerp(rate_m_lut, s, w)) >> 14);
      dh = decay_q30((dt_step * lerp(rate_h_lut, s, w)) >> 14);
      act_m = approach(act_m, mt, dm) & 64'h1FFFF;
      inact_h = approach(inact_h, ht, dh) & 64'hFFFFF;
    end
    diff = v - e_rev;
    gmh = (g_nS * act_m * inact_h) >> 24;
    mag = (gmh * longint'(diff < 0 ? -diff : diff)) >> 16;
    if (mag > 64'h80000000) mag = 64'h80000000;
    if (diff >= 0 && mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
    r.current = (diff < 0) ? -32'(mag) : 32'(mag);
    r.activation = act_m[16:0];
    r.inactivation = inact_h[19:0];
    return r;
  endfunction

  // Drives one transaction; valid is left high so back-to-back items need no gap.
  task automatic send(logic [1:0] fn, logic signed [15:0] volt, bit zero_expected);
    ccg_pkg::out_item_t r;
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data.func <= fn;
    in_data.voltage <= volt;
    do @(posedge clk_i); while (!in_ready);
    r = gate_response(fn, volt);
    if (zero_expected) r = '0;
    pending_results.push_back(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Let the block finish any work still in flight after the last transaction.
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(ccg_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      ccg_pkg::CFG_CONDUCTANCE: g_nS = val;
      ccg_pkg::CFG_REVERSAL:    e_rev = longint'($signed(val));
      default:                  dt_step = val;
    endcase
  endtask

  task automatic random_item();
    logic [1:0] fn;
    logic signed [15:0] volt;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) fn = ccg_pkg::FUNC_STEP;
    else if (pick < 75) fn = ccg_pkg::FUNC_SET;
    else if (pick < 90) fn = ccg_pkg::FUNC_QUERY;
    else fn = FUNC_UNUSED;
    pick = $urandom_range(9);
    if (pick < 5) volt = $signed(16'($urandom_range(0, 40960))) - 16'sd25600;
    else if (pick == 5) volt = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    else volt = 16'($urandom());
    send(fn, volt, 1'b0);
  endtask

  typedef struct {
    logic [1:0] fn;
    logic signed [15:0] volt;
    bit zero_expected;
  } dir_row_t;

  dir_row_t dir_rows[14] = '{
    '{ccg_pkg::FUNC_QUERY,  16'sd0,       1'b1},  // gates read zero before priming
    '{FUNC_UNUSED,          16'sh8000,    1'b1},
    '{ccg_pkg::FUNC_STEP,   -16'sd5120,   1'b0},  // first step snaps to the targets
    '{ccg_pkg::FUNC_STEP,   -16'sd2560,   1'b0},
    '{ccg_pkg::FUNC_STEP,   16'sh7FFF,    1'b0},
    '{ccg_pkg::FUNC_STEP,   16'sh8000,    1'b0},
    '{ccg_pkg::FUNC_SET,    16'sd0,       1'b0},
    '{ccg_pkg::FUNC_QUERY,  16'sh7FFF,    1'b0},
    '{ccg_pkg::FUNC_QUERY,  16'sh8000,    1'b0},
    '{FUNC_UNUSED,          16'sd3840,    1'b0},
    '{ccg_pkg::FUNC_STEP,   16'sd2560,    1'b0},
    '{ccg_pkg::FUNC_SET,    16'sh8000,    1'b0},
    '{ccg_pkg::FUNC_STEP,   16'sd15360,   1'b0},  // at the reversal potential
    '{ccg_pkg::FUNC_SET,    16'sh7FFF,    1'b0}
  };

  // Result checker.
  always @(posedge clk_i) begin
    ccg_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.current !== out_data.current || want.activation !== out_data.activation
            || want.inactivation !== out_data.inactivation) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected cur=%0d m=%0d h=%0d, got cur=%0d m=%0d h=%0d",
                     want.current, want.activation, want.inactivation,
                     out_data.current, out_data.activation, out_data.inactivation);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end else if (!quiet && $urandom_range(7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("calcium_channel_gate_update regression: fail");
    $finish;
  end

  initial begin
    logic [15:0] g_set[6] = '{16'd256, 16'd0, 16'd65535, 16'd4096, 16'd1000, 16'd300};
    logic [15:0] e_set[6] = '{16'h8000, 16'h7FFF, 16'h3C00, 16'hEC00, 16'h0000, 16'h1000};
    logic [15:0] dt_set[6] = '{16'd1, 16'd65535, 16'd1024, 16'd200, 16'd8000, 16'd40};
    build_luts();
    g_nS = 256;
    e_rev = 15360;
    dt_step = 1024;
    act_m = 0;
    inact_h = 0;
    gates_primed = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i].fn, dir_rows[i].volt, dir_rows[i].zero_expected);
    drain();
    // A zero time step leaves the gates where they are.
    write_reg(ccg_pkg::CFG_TIME_STEP, 16'd0);
    send(ccg_pkg::FUNC_STEP, -16'sd10240, 1'b0);
    send(ccg_pkg::FUNC_STEP, 16'sd5120, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ccg_pkg::CFG_CONDUCTANCE, (ph == 5) ? 16'($urandom()) : g_set[ph]);
      write_reg(ccg_pkg::CFG_REVERSAL, (ph == 5) ? 16'($urandom()) : e_set[ph]);
      write_reg(ccg_pkg::CFG_TIME_STEP, dt_set[ph]);
      if (ph == 2) hold_off = 1;
      if (ph == 5) quiet = 1;
      for (int n = 0; n < 190; n++) random_item();
      drain();
    end

    if (errors == 0) $display("calcium_channel_gate_update regression: pass");
    else $display("calcium_channel_gate_update regression: fail");
    $finish;
  end

endmodule
